// ----- rtl/framed_command_sample_link_macros.svh -----
// Assertion macros shared by the link RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FRAMED_COMMAND_SAMPLE_LINK_MACROS_SVH
`define FRAMED_COMMAND_SAMPLE_LINK_MACROS_SVH

// Same-cycle implication.
`define FLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/flc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_pkg
// Types, constants and the frame byte builder for the command/sample link.
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam logic [7:0] FLC_STX       = 8'h02;
  localparam logic [7:0] FLC_ETX       = 8'h03;
  localparam logic [7:0] FLC_CMD_START = 8'h06;
  localparam logic [7:0] FLC_CMD_STOP  = 8'h07;
  localparam logic [7:0] FLC_OUT_LEN   = 8'd9;
  localparam int unsigned FLC_WIN      = 6;
  localparam int unsigned FLC_QUEUE_DEPTH = 2;

  // Input beat kinds.
  localparam logic FLC_ACT_BYTE   = 1'b0;
  localparam logic FLC_ACT_SAMPLE = 1'b1;

  // Byte positions inside an outgoing frame.
  typedef enum logic [3:0] {
    POS_STX,
    POS_LEN,
    POS_CMD,
    POS_LO,
    POS_HI,
    POS_SUM_LO,
    POS_SUM_HI,
    POS_ETX0,
    POS_ETX1
  } flc_pos_t;

  // One sample frame waiting to be sent. The sum never exceeds 9+255+255+3.
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] lo;
    logic [1:0] hi;
    logic [9:0] sum;
  } flc_job_t;

  // Job plus its valid flag, as it moves between front, queue and back.
  typedef struct packed {
    logic     valid;
    flc_job_t job;
  } flc_qbeat_t;

  function automatic logic [7:0] flc_frame_byte(input flc_job_t job, input flc_pos_t pos);
    logic [7:0] b;
    case (pos)
      POS_STX:    b = FLC_STX;
      POS_LEN:    b = FLC_OUT_LEN;
      POS_CMD:    b = job.cmd;
      POS_LO:     b = job.lo;
      POS_HI:     b = {6'b0, job.hi};
      POS_SUM_LO: b = job.sum[7:0];
      POS_SUM_HI: b = {6'b0, job.sum[9:8]};
      POS_ETX0:   b = FLC_ETX;
      POS_ETX1:   b = FLC_ETX;
      default:    b = FLC_ETX;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/flc_channels_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_channels_if
// Valid/ready channels of the link: incoming beats and outgoing frame bytes.
// ----------------------------------------------------------------------------
interface flc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [9:0] sample;

  modport source (output valid, action, rx_byte, sample, input ready);
  modport sink   (input valid, action, rx_byte, sample, output ready);
endinterface

interface flc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_last;

  modport source (output valid, tx_byte, frame_last, input ready);
  modport sink   (input valid, tx_byte, frame_last, output ready);
endinterface

// ----- rtl/flc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_queue
// Small register FIFO of pending sample frames between front and back.
// ----------------------------------------------------------------------------
module flc_queue #(
  parameter int unsigned Depth = flc_pkg::FLC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  flc_pkg::flc_qbeat_t push,
  output logic               push_ready,
  input  logic               pop,
  output flc_pkg::flc_qbeat_t head
);
  import flc_pkg::*;
  `include "framed_command_sample_link_macros.svh"

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  flc_job_t            mem [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  `FLC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CntW'(Depth), "queue count above depth")
  `FLC_ASSERT_NOW(a_no_push_full, push.valid, push_ready, "push offered to a full queue")
  `FLC_ASSERT_NOW(a_no_pop_empty, pop, head.valid, "pop from an empty queue")
  `FLC_ASSERT_NEXT(a_push_fills, do_push && !do_pop, count_r != '0, "push left queue empty")
endmodule

// ----- rtl/flc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_front
// Takes input beats, decodes command frames from the receive window and
// turns samples taken while running into queued frame jobs.
// ----------------------------------------------------------------------------
module flc_front (
  input  logic                clk,
  input  logic                rst_n,
  flc_in_if.sink              in_ch,
  output flc_pkg::flc_qbeat_t push,
  input  logic                push_ready
);
  import flc_pkg::*;

  logic [7:0] win_r   [FLC_WIN];
  logic [7:0] win_nxt [FLC_WIN];
  logic       running_r, running_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       accept;
  logic       frame_ok;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Window as it reads once the incoming byte has shifted in, oldest first.
  always_comb begin
    for (int i = 0; i < FLC_WIN - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[FLC_WIN - 1] = in_ch.rx_byte;
  end

  assign frame_ok = (win_nxt[0] == FLC_STX) && (win_nxt[4] == FLC_ETX) &&
                    (win_nxt[5] == FLC_ETX) &&
                    (win_nxt[3] == 8'(win_nxt[1] + win_nxt[2]));

  always_comb begin
    running_nxt = running_r;
    cmd_nxt     = cmd_r;
    if (accept && (in_ch.action == FLC_ACT_BYTE) && frame_ok) begin
      if (win_nxt[2] == FLC_CMD_START) begin
        running_nxt = 1'b1;
        cmd_nxt     = win_nxt[2];
      end else if (win_nxt[2] == FLC_CMD_STOP) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    push.valid   = accept && (in_ch.action == FLC_ACT_SAMPLE) && running_r;
    push.job.cmd = cmd_r;
    push.job.lo  = in_ch.sample[7:0];
    push.job.hi  = in_ch.sample[9:8];
    push.job.sum = 10'(FLC_OUT_LEN) + {2'b0, cmd_r} + {2'b0, in_ch.sample[7:0]} +
                   {8'b0, in_ch.sample[9:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FLC_WIN; i++) begin
        win_r[i] <= '0;
      end
      running_r <= 1'b0;
      cmd_r     <= '0;
    end else begin
      if (accept && (in_ch.action == FLC_ACT_BYTE)) begin
        for (int i = 0; i < FLC_WIN; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
      running_r <= running_nxt;
      cmd_r     <= cmd_nxt;
    end
  end
endmodule

// ----- rtl/flc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_back
// Pulls frame jobs from the queue and sends each one as nine bytes through
// a registered output stage.
// ----------------------------------------------------------------------------
module flc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  flc_pkg::flc_qbeat_t head,
  output logic                pop,
  flc_out_if.source           out_ch
);
  import flc_pkg::*;
  `include "framed_command_sample_link_macros.svh"

  logic       busy_r, busy_nxt;
  flc_pos_t   pos_r, pos_nxt;
  flc_job_t   job_r, job_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       adv;

  // The output register can take a new byte when empty or being drained.
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (adv) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = flc_frame_byte(job_r, pos_r);
        out_last_nxt  = (pos_r == POS_ETX1);
        if (pos_r == POS_ETX1) begin
          // Pick up the next job right away so frames run back to back.
          pop      = head.valid;
          busy_nxt = head.valid;
          job_nxt  = head.job;
          pos_nxt  = POS_STX;
        end else begin
          pos_nxt = flc_pos_t'(pos_r + 4'd1);
        end
      end else begin
        out_valid_nxt = 1'b0;
        pop           = head.valid;
        busy_nxt      = head.valid;
        job_nxt       = head.job;
        pos_nxt       = POS_STX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= POS_STX;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_byte    = out_byte_r;
  assign out_ch.frame_last = out_last_r;

  `FLC_ASSERT_NOW(a_last_is_etx, out_valid_r && out_last_r, out_byte_r == FLC_ETX,
    "frame end beat is not ETX")
  `FLC_ASSERT_NOW(a_pop_slot, pop, !busy_r || (adv && pos_r == POS_ETX1),
    "job taken while a frame is in progress")
  `FLC_ASSERT_NEXT(a_pop_starts, pop, busy_r && pos_r == POS_STX,
    "popped job did not start at STX")
  `FLC_ASSERT_NEXT(a_stx_after_last, adv && busy_r && pos_r == POS_ETX1 && head.valid,
    out_valid_r && out_last_r, "last beat not flagged")
endmodule

// ----- rtl/framed_command_sample_link.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_sample_link
// Serial command receiver and converter sample framer.
// ----------------------------------------------------------------------------
// Input beats are taken one per cycle while the job queue has room: a
// received byte updates the six-byte command window (start/stop frames take
// effect for the next beat), and a sample taken while the link runs becomes
// one queued job. The sender sends each job as nine output beats, one per
// cycle while the output is ready, through a single output register, frames
// back to back; a sample passes the queue, the sender's job register and the
// output register. QUEUE_DEPTH (at least 2) sets how many samples may wait
// behind the frame in flight.
module framed_command_sample_link #(
  parameter int unsigned QUEUE_DEPTH = flc_pkg::FLC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  flc_in_if.sink    in_ch,
  flc_out_if.source out_ch
);
  import flc_pkg::*;

  flc_qbeat_t q_push;
  flc_qbeat_t q_head;
  logic       q_push_ready;
  logic       q_pop;

  flc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (q_push),
    .push_ready (q_push_ready)
  );

  flc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .head       (q_head)
  );

  flc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );
endmodule

// ----- verif/flc_link_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_link_checker
// Watches both link channels, tracks the command window and the run state,
// builds the nine-byte frame each accepted sample should produce, and compares
// every outgoing beat with the oldest byte still owed.
// ----------------------------------------------------------------------------
module flc_link_checker
  import flc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  flc_in_if           in_mon,
  flc_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_bytes,
  output int unsigned frames_checked
);

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_last;
  } tx_beat_t;

  tx_beat_t   owed_tx_q[$];
  logic [7:0] rx_window [0:FLC_WIN-1];
  logic       link_running;
  logic [7:0] latched_cmd;
  tx_beat_t   oldest;

  task automatic shift_rx_window(input logic [7:0] b);
    logic [7:0] chk;
    for (int i = 0; i < FLC_WIN - 1; i++) rx_window[i] = rx_window[i+1];
    rx_window[FLC_WIN-1] = b;
    chk = rx_window[1] + rx_window[2];
    if (rx_window[0] == FLC_STX && rx_window[4] == FLC_ETX &&
        rx_window[5] == FLC_ETX && rx_window[3] == chk) begin
      if (rx_window[2] == FLC_CMD_START) begin
        latched_cmd  = rx_window[2];
        link_running = 1'b1;
      end else if (rx_window[2] == FLC_CMD_STOP) begin
        link_running = 1'b0;
      end
    end
  endtask

  task automatic queue_sample_frame(input logic [9:0] s);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] total;
    lo    = s[7:0];
    hi    = {6'b0, s[9:8]};
    total = 16'(FLC_OUT_LEN) + 16'(latched_cmd) + 16'(lo) + 16'(hi);
    owed_tx_q.push_back('{FLC_STX, 1'b0});
    owed_tx_q.push_back('{FLC_OUT_LEN, 1'b0});
    owed_tx_q.push_back('{latched_cmd, 1'b0});
    owed_tx_q.push_back('{lo, 1'b0});
    owed_tx_q.push_back('{hi, 1'b0});
    owed_tx_q.push_back('{total[7:0], 1'b0});
    owed_tx_q.push_back('{total[15:8], 1'b0});
    owed_tx_q.push_back('{FLC_ETX, 1'b0});
    owed_tx_q.push_back('{FLC_ETX, 1'b1});
  endtask

  initial begin
    mismatch_count = 0;
    pending_bytes  = 0;
    frames_checked = 0;
    link_running   = 1'b0;
    latched_cmd    = 8'h00;
    for (int i = 0; i < FLC_WIN; i++) rx_window[i] = 8'h00;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_tx_q.delete();
      link_running = 1'b0;
      latched_cmd  = 8'h00;
      for (int i = 0; i < FLC_WIN; i++) rx_window[i] = 8'h00;
    end else begin
      // The outgoing beat is checked first: a byte of a frame whose sample is
      // accepted on this same edge would be too early and must not match.
      if (out_mon.valid && out_mon.ready) begin
        if (owed_tx_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat tx_byte=%h frame_last=%b", $time,
                   out_mon.tx_byte, out_mon.frame_last);
        end else begin
          oldest = owed_tx_q.pop_front();
          if (out_mon.tx_byte !== oldest.tx_byte) begin
            mismatch_count++;
            $display("%0t: tx_byte expected %h actual %h", $time,
                     oldest.tx_byte, out_mon.tx_byte);
          end
          if (out_mon.frame_last !== oldest.frame_last) begin
            mismatch_count++;
            $display("%0t: frame_last expected %b actual %b", $time,
                     oldest.frame_last, out_mon.frame_last);
          end
          if (oldest.frame_last) frames_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == FLC_ACT_BYTE) shift_rx_window(in_mon.rx_byte);
        else if (link_running) queue_sample_frame(in_mon.sample);
      end
    end
    pending_bytes = owed_tx_q.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the framed command/sample link.
// Sends a directed opening (start, stop, extreme samples, dropped samples)
// and then random command frames, broken frames, noise and sample bursts,
// with random gaps on both channels and one stretch without any.
// ----------------------------------------------------------------------------
module tb;
  import flc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned beats_sent;
  int unsigned useful_items;
  int unsigned mismatch_count;
  int unsigned pending_bytes;
  int unsigned frames_checked;

  flc_in_if  in_ch ();
  flc_out_if out_ch ();

  framed_command_sample_link u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  flc_link_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_bytes  (pending_bytes),
    .frames_checked (frames_checked)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // One input beat: optional random gap, then hold it until it is taken.
  task automatic send_beat(input logic act, input logic [7:0] b, input logic [9:0] s);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= b;
    in_ch.sample  <= s;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(FLC_ACT_BYTE, b, 10'($urandom));
    useful_items++;
  endtask

  task automatic send_sample(input logic [9:0] s);
    send_beat(FLC_ACT_SAMPLE, 8'($urandom), s);
    useful_items++;
  endtask

  task automatic send_frame(input logic [7:0] stx, input logic [7:0] len,
                            input logic [7:0] cmd, input logic [7:0] chk,
                            input logic [7:0] etx0, input logic [7:0] etx1);
    send_byte(stx);
    send_byte(len);
    send_byte(cmd);
    send_byte(chk);
    send_byte(etx0);
    send_byte(etx1);
  endtask

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] bad;
    int unsigned pick;

    rst_n          = 1'b0;
    calm           = 1'b0;
    beats_sent     = 0;
    useful_items   = 0;
    in_ch.valid    = 1'b0;
    in_ch.action   = FLC_ACT_BYTE;
    in_ch.rx_byte  = 8'h00;
    in_ch.sample   = 10'h000;
    out_ch.ready   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening.
    send_sample(10'h3FF);  // dropped: the link is still stopped
    send_frame(FLC_STX, 8'h10, FLC_CMD_STOP, 8'h17, FLC_ETX, FLC_ETX);
    send_frame(FLC_STX, 8'hFF, FLC_CMD_START, 8'h05, FLC_ETX, FLC_ETX);
    send_sample(10'h000);
    send_sample(10'h3FF);
    send_sample(10'h0FF);
    send_sample(10'h300);
    // A second start while running keeps the link up and sends nothing.
    send_frame(FLC_STX, 8'h00, FLC_CMD_START, 8'h06, FLC_ETX, FLC_ETX);
    send_sample(10'h155);
    send_frame(FLC_STX, 8'h00, FLC_CMD_STOP, 8'h07, FLC_ETX, FLC_ETX);
    send_sample(10'h2AA);

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      calm = (useful_items >= 200 && useful_items < 300);
      pick = $urandom_range(0, 99);
      len  = 8'($urandom);
      if (pick < 12) begin
        send_frame(FLC_STX, len, FLC_CMD_START, len + FLC_CMD_START, FLC_ETX, FLC_ETX);
      end else if (pick < 18) begin
        send_frame(FLC_STX, len, FLC_CMD_STOP, len + FLC_CMD_STOP, FLC_ETX, FLC_ETX);
      end else if (pick < 24) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 30) begin
        // Start frame with one field broken.
        bad = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 3))
          0: send_frame(FLC_STX ^ bad, len, FLC_CMD_START, len + FLC_CMD_START,
                        FLC_ETX, FLC_ETX);
          1: send_frame(FLC_STX, len, FLC_CMD_START, len + FLC_CMD_START + bad,
                        FLC_ETX, FLC_ETX);
          2: send_frame(FLC_STX, len, FLC_CMD_START, len + FLC_CMD_START,
                        FLC_ETX ^ bad, FLC_ETX);
          default: send_frame(FLC_STX, len, FLC_CMD_START, len + FLC_CMD_START,
                              FLC_ETX, FLC_ETX ^ bad);
        endcase
      end else if (pick < 34) begin
        // Well-formed frame with a command the link does not act on.
        do cmd = 8'($urandom); while (cmd == FLC_CMD_START || cmd == FLC_CMD_STOP);
        send_frame(FLC_STX, len, cmd, len + cmd, FLC_ETX, FLC_ETX);
      end else begin
        repeat ($urandom_range(1, 6)) send_sample(10'($urandom));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input beats; checked %0d outgoing frames.", beats_sent, frames_checked);
    $display("Covered start/stop frames, broken and foreign frames, noise and samples.");
    if (pending_bytes != 0)
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes);
    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
